// File: rtl/tilt_compensated_heading_core_defines.svh
// assertion macros used by the checker file
`ifndef TILT_COMPENSATED_HEADING_CORE_DEFINES_SVH
`define TILT_COMPENSATED_HEADING_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define TCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tch_pkg.sv
// ---------------------------------------------------------------------------
// tch_pkg
// types, constants and helpers for the tilt-compensated heading core
// ---------------------------------------------------------------------------
package tch_pkg;

    localparam int CordicStagesDefault = 16;
    localparam int SampleBitsDefault   = 16;
    localparam int AtanEntries         = 24;
    localparam int DataW               = 34;
    localparam int MulW                = 31;
    localparam logic [MulW-1:0] KinvQ30 = MulW'(652032874);
    localparam logic [31:0] HalfTurn    = 32'h8000_0000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] heading_angle;
        logic               accel_zero;
    } out_word_t;

    typedef logic signed [DataW-1:0] data_t;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic data_t abs_d(input data_t v);
        return v[DataW-1] ? -v : v;
    endfunction

    // left shift count that brings the larger magnitude into [2^28, 2^29)
    function automatic logic [4:0] norm_cnt(input data_t m);
        logic [4:0] k;
        k = 5'd0;
        for (int b = 28; b >= 0; b--)
        begin
            if (m[b] && k == 5'd0 && m < (data_t'(1) <<< 28))
                k = 5'(28 - b);
        end
        if (m == '0)
            k = 5'd0;
        return k;
    endfunction

    // rounded binary angle to 16 bits
    function automatic logic [15:0] out16(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h0000_8000;
        return t[31:16];
    endfunction

endpackage

// File: rtl/tilt_compensated_heading_core.sv
// ---------------------------------------------------------------------------
// tilt_compensated_heading_core
// roll, pitch and tilt-compensated heading from one accel and mag sample
// ---------------------------------------------------------------------------
// One sample is taken every clock cycle and gives one result word. A fixed
// pipeline of five CORDIC chains, each of CORDIC_STAGES (at most 24) registered
// micro-rotations, plus normalization and gain-removal registers, feeds the
// output register;
// the whole pipe stalls as one when the output register is full and not taken.
module tilt_compensated_heading_core
#(
    parameter int CORDIC_STAGES = tch_pkg::CordicStagesDefault,
    parameter int SAMPLE_BITS   = tch_pkg::SampleBitsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tch_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tch_pkg::out_word_t out_data
);
    import tch_pkg::*;

    localparam int N = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
    localparam int SxShift = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

    // item carried along the pipe
    typedef struct packed {
        logic        zero;
        logic        roll_undef;
        logic [4:0]  k0;
        logic [4:0]  k1;
        data_t       ax;
        data_t       my;
        data_t       mx;
        data_t       mz;
        data_t       x;
        data_t       y;
        logic [31:0] z;
        logic [31:0] roll;
        logic [31:0] pitch;
        data_t       a;
        data_t       b;
    } item_t;

    localparam int Depth = 5 * N + 14;

    item_t          st_reg  [Depth];
    item_t          st_next [Depth];
    logic [Depth-1:0] v_reg;
    logic           adv;
    out_word_t      out_reg;
    logic           out_v_reg;

    // whole pipe advances unless the output register holds an untaken word
    assign adv      = !out_v_reg || out_ready;
    assign in_ready = adv;

    // sign extension within SAMPLE_BITS
    function automatic data_t sx(input logic [15:0] v);
        logic [15:0] t;
        t = v << SxShift;
        return DataW'($signed(t) >>> SxShift);
    endfunction

    // vectoring micro-rotation
    function automatic item_t vstep(input item_t s, input int i);
        item_t r;
        data_t dx;
        data_t dy;
        r  = s;
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (!s.y[DataW-1])
        begin
            r.x = s.x + dx; r.y = s.y - dy; r.z = s.z + atan_lut(i);
        end
        else
        begin
            r.x = s.x - dx; r.y = s.y + dy; r.z = s.z - atan_lut(i);
        end
        return r;
    endfunction

    // rotation micro-rotation, residual angle in z
    function automatic item_t rstep(input item_t s, input int i);
        item_t r;
        data_t dx;
        data_t dy;
        r  = s;
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (!s.z[31])
        begin
            r.x = s.x - dx; r.y = s.y + dy; r.z = s.z - atan_lut(i);
        end
        else
        begin
            r.x = s.x + dx; r.y = s.y - dy; r.z = s.z + atan_lut(i);
        end
        return r;
    endfunction

    // vectoring prefold: left half-plane flips and adds half a turn
    function automatic item_t vpre(input item_t s);
        item_t r;
        r   = s;
        r.z = 32'd0;
        if (s.x[DataW-1])
        begin
            r.x = -s.x; r.y = -s.y; r.z = HalfTurn;
        end
        return r;
    endfunction

    // rotation prefold into [-quarter, quarter]
    function automatic item_t rpre(input item_t s);
        item_t r;
        logic signed [32:0] zz;
        r  = s;
        zz = 33'($signed(s.z));
        if (zz > 33'sd1073741824 || zz < -33'sd1073741824)
        begin
            r.x = -s.x; r.y = -s.y;
            r.z = s.z + HalfTurn;
        end
        return r;
    endfunction

    data_t mk_in  [3];
    data_t mk_out [3];
    data_t yk_q;

    // stage layout indices
    localparam int S_ROLL  = 1;             // roll vectoring begins
    localparam int S_RK    = S_ROLL + N + 1;
    localparam int S_PIT   = S_RK + 3;      // pitch vectoring begins
    localparam int S_R1    = S_PIT + N + 1; // pitch rotation begins
    localparam int S_K1    = S_R1 + N + 1;
    localparam int S_R2    = S_K1 + 2;      // roll rotation begins
    localparam int S_K2    = S_R2 + N + 1;
    localparam int S_HD    = S_K2 + 3;      // heading vectoring begins

    tch_mulk u_mk0 (.clk(clk), .en(adv), .v(mk_in[0]), .q(mk_out[0]));
    tch_mulk u_mk1 (.clk(clk), .en(adv), .v(mk_in[1]), .q(mk_out[1]));
    tch_mulk u_mk2 (.clk(clk), .en(adv), .v(mk_in[2]), .q(mk_out[2]));

    // gain removal of yh after the roll rotation
    tch_mulk u_mk3 (.clk(clk), .en(adv), .v(st_reg[S_K2-1].x), .q(yk_q));

    assign mk_in[0] = st_reg[S_RK - 1].x;
    assign mk_in[1] = st_reg[S_K1 - 1].x;
    assign mk_in[2] = st_reg[S_K1 - 1].y;

    // next values of every stage
    always_comb
    begin
        item_t  t;
        data_t  ax, ay, az, mx, my, mz, m, sh, yh;
        logic [4:0] k;
        st_next[0] = st_reg[0];
        for (int j = 1; j < Depth; j++)
            st_next[j] = st_reg[j-1];

        // input stage: sign extend, normalize roll vector and magnetic vector
        ax = sx(in_data.accel_x); ay = sx(in_data.accel_y); az = sx(in_data.accel_z);
        mx = sx(in_data.mag_x);   my = sx(in_data.mag_y);   mz = sx(in_data.mag_z);
        t = '0;
        t.zero       = (ax == '0) && (ay == '0) && (az == '0);
        t.roll_undef = (ay == '0) && (az == '0);
        m = (abs_d(ay) > abs_d(az)) ? abs_d(ay) : abs_d(az);
        t.k1 = norm_cnt(m);
        m = (abs_d(ax) > m) ? abs_d(ax) : m;
        t.k0 = norm_cnt(m);
        m = (abs_d(my) > abs_d(mx)) ? abs_d(my) : abs_d(mx);
        m = (abs_d(mz) > m) ? abs_d(mz) : m;
        k = norm_cnt(m);
        t.ax = ax;
        t.mx = mx <<< k; t.my = my <<< k; t.mz = mz <<< k;
        t.x  = az <<< t.k1; t.y = ay <<< t.k1;
        st_next[0] = t;

        // roll vectoring
        st_next[S_ROLL] = vpre(st_reg[S_ROLL-1]);
        for (int i = 0; i < N; i++)
            st_next[S_ROLL+1+i] = vstep(st_reg[S_ROLL+i], i);
        // hold roll angle; magnitude into gain removal
        t = st_reg[S_RK-1];
        t.roll = t.roll_undef ? 32'd0 : t.z;
        st_next[S_RK] = t;
        // after gain removal: pitch vector
        t = st_reg[S_RK+1];
        sh = t.roll_undef ? data_t'(0) : (mk_out[0] >>> (t.k1 - t.k0));
        t.x = sh;
        t.y = -(t.ax <<< t.k0);
        st_next[S_RK+2] = t;
        st_next[S_PIT] = vpre(st_reg[S_PIT-1]);
        for (int i = 0; i < N; i++)
            st_next[S_PIT+1+i] = vstep(st_reg[S_PIT+i], i);
        // pitch rotation of (mx, mz) by -pitch
        t = st_reg[S_R1-1];
        t.pitch = t.z;
        t.x = t.mx; t.y = t.mz; t.z = 32'd0 - t.z;
        st_next[S_R1] = rpre(t);
        for (int i = 0; i < N; i++)
            st_next[S_R1+1+i] = rstep(st_reg[S_R1+i], i);
        st_next[S_K1] = st_reg[S_K1-1];
        // roll rotation of (my, z') once xh and z' have left gain removal
        t = st_reg[S_K1+1];
        t.a = mk_out[1];
        t.x = t.my; t.y = mk_out[2]; t.z = t.roll;
        st_next[S_R2] = rpre(t);
        for (int i = 0; i < N; i++)
            st_next[S_R2+1+i] = rstep(st_reg[S_R2+i], i);
        // heading vector from xh and the gain-removed yh, normalized
        t = st_reg[S_K2+1];
        yh = yk_q;
        t.b = yh;
        m = (abs_d(yh) > abs_d(t.a)) ? abs_d(yh) : abs_d(t.a);
        k = norm_cnt(m);
        t.x = t.a <<< k; t.y = -(yh <<< k);
        st_next[S_HD-1] = t;
        st_next[S_HD] = vpre(st_reg[S_HD-1]);
        for (int i = 0; i < N; i++)
            st_next[S_HD+1+i] = vstep(st_reg[S_HD+i], i);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < Depth; j++)
                st_reg[j] <= st_next[j];
        end
    end

    // valid bits and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[Depth-2:0], in_valid};
            out_v_reg <= v_reg[Depth-1];
        end
    end

    // final rounding and special cases
    always_ff @(posedge clk)
    begin
        logic [15:0] p;
        if (adv)
        begin
            p = out16(st_reg[Depth-1].pitch);
            if (p >= 16'h8000 && p < 16'hC000)
                p = 16'hC000;
            else if (p > 16'h4000 && p < 16'h8000)
                p = 16'h4000;
            if (st_reg[Depth-1].zero)
                out_reg <= '{roll_angle: '0, pitch_angle: '0, heading_angle: '0,
                             accel_zero: 1'b1};
            else
                out_reg <= '{roll_angle: out16(st_reg[Depth-1].roll), pitch_angle: p,
                             heading_angle: (st_reg[Depth-1].a == '0 &&
                                 st_reg[Depth-1].b == '0) ? 16'd0
                                 : out16(st_reg[Depth-1].z),
                             accel_zero: 1'b0};
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
endmodule

// File: rtl/tch_mulk.sv
// ---------------------------------------------------------------------------
// tch_mulk
// registered gain removal: (v * 1/K + 2^29) >> 30, two stages
// ---------------------------------------------------------------------------
module tch_mulk
(
    input  logic                 clk,
    input  logic                 en,
    input  tch_pkg::data_t       v,
    output tch_pkg::data_t       q
);
    import tch_pkg::*;

    localparam int ProdW = DataW + MulW + 1;

    logic signed [ProdW-1:0] prod_reg;
    logic signed [ProdW-1:0] prod_next;
    data_t                   q_reg;
    logic signed [ProdW-1:0] rnd;

    // product with the rounding constant folded in
    assign prod_next = ProdW'(v) * $signed({1'b0, KinvQ30}) + (ProdW'(1) <<< 29);
    assign rnd       = prod_reg >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            q_reg    <= DataW'(rnd);
        end
    end

    assign q = q_reg;
endmodule

// File: rtl/tch_checker.sv
// ---------------------------------------------------------------------------
// tch_checker
// port-level checks of the heading core, bound to the top level
// ---------------------------------------------------------------------------
`include "tilt_compensated_heading_core_defines.svh"
module tch_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input tch_pkg::out_word_t out_data
);
    import tch_pkg::*;

    `TCH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output word dropped while stalled")
    `TCH_ASSERT_IMPL(a_ready_stall, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken during output stall")
    `TCH_ASSERT_IMPL(a_zero_angles, clk, rst_n, out_valid && out_data.accel_zero, out_data.roll_angle == '0 && out_data.heading_angle == '0, "zero accel gave angles")
    `TCH_ASSERT_IMPL(a_pitch_range, clk, rst_n, out_valid, $signed(out_data.pitch_angle) <= 16'sd16384 && $signed(out_data.pitch_angle) >= -16'sd16384, "pitch out of range")
endmodule

bind tilt_compensated_heading_core tch_checker u_tch_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
